// ----- rtl/core/transmit_request_frame_builder_macros.svh -----
// Assertion macros shared by the transmit-request frame builder RTL.
`ifndef TRANSMIT_REQUEST_FRAME_BUILDER_MACROS_SVH
`define TRANSMIT_REQUEST_FRAME_BUILDER_MACROS_SVH

`ifndef ASSERT_OFF
// Check that a condition implies another in the same cycle.
`define TRFB_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("implication check failed");
// Check that a condition implies another in the next cycle.
`define TRFB_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("next-cycle check failed");
`else
`define TRFB_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define TRFB_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ----- rtl/core/trfb_pkg.sv -----
// Shared types and constants of the transmit-request frame builder.
`default_nettype none
package trfb_pkg;

    // Command queue depth between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Fixed frame bytes
    localparam logic [7:0] START_DELIM  = 8'h7E;
    localparam logic [7:0] LEN_HI       = 8'h00;
    localparam logic [7:0] LEN_BASE     = 8'h0E;
    localparam logic [7:0] FRAME_TYPE   = 8'h10;
    localparam logic [7:0] FRAME_ID     = 8'h00;
    localparam logic [7:0] NET_ADDR_HI  = 8'hFF;
    localparam logic [7:0] NET_ADDR_LO  = 8'hFE;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;

    // One classified item, handed from front to back
    typedef struct packed {
        logic        first;     // opens a frame: emit header
        logic        has_data;  // carries a payload byte
        logic        last;      // closes the frame: emit checksum
        logic [63:0] addr;
        logic [7:0]  len;
        logic [7:0]  data;
    } t_cmd;

    // Byte position within the work of one command
    typedef enum logic [4:0] {
        ST_SOF,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_TYPE,
        ST_FID,
        ST_ADDR0,
        ST_ADDR1,
        ST_ADDR2,
        ST_ADDR3,
        ST_ADDR4,
        ST_ADDR5,
        ST_ADDR6,
        ST_ADDR7,
        ST_NET_HI,
        ST_NET_LO,
        ST_RADIUS,
        ST_OPTIONS,
        ST_DATA,
        ST_CSUM
    } t_step;

endpackage
`default_nettype wire

// ----- rtl/core/trfb_front.sv -----
// Front end: accepts items, tracks the open frame and classifies each beat.
`default_nettype none
module trfb_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  wire             i_q_full,
    input  wire      [63:0] i_dest_address,
    input  wire      [7:0]  i_payload_length,
    input  wire      [7:0]  i_payload_byte,
    output logic            o_q_push,
    output trfb_pkg::t_cmd  o_cmd
);
    import trfb_pkg::*;

    logic [7:0] r_left;
    logic [7:0] n_left;
    logic       first;
    logic [7:0] left_after;

    // Classify the incoming beat against the open frame
    always_comb begin
        first      = (r_left == 8'd0);
        left_after = (first ? i_payload_length : r_left) - 8'd1;
        o_cmd.first    = first;
        o_cmd.has_data = !first || (i_payload_length != 8'd0);
        o_cmd.last     = o_cmd.has_data ? (left_after == 8'd0) : 1'b1;
        o_cmd.addr     = i_dest_address;
        o_cmd.len      = i_payload_length;
        o_cmd.data     = i_payload_byte;
        o_q_push       = i_push && !i_q_full;
        n_left         = r_left;
        if (o_q_push && o_cmd.has_data) begin
            n_left = left_after;
        end
    end

    // Advance the remaining payload count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 8'd0;
        end else begin
            r_left <= n_left;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/trfb_cmd_fifo.sv -----
// Short command queue between the front end and the byte sequencer.
`default_nettype none
`include "transmit_request_frame_builder_macros.svh"
module trfb_cmd_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  trfb_pkg::t_cmd  i_cmd,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_empty,
    output trfb_pkg::t_cmd  o_cmd
);
    import trfb_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr;
    logic [CMD_PTR_W-1:0] r_rd;
    logic [CMD_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + CMD_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + CMD_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CMD_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CMD_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `TRFB_ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)

endmodule
`default_nettype wire

// ----- rtl/core/trfb_back.sv -----
// Back end: steps through the bytes of each command into the output register.
`default_nettype none
`include "transmit_request_frame_builder_macros.svh"
module trfb_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_q_empty,
    input  trfb_pkg::t_cmd  i_cmd,
    output logic            o_q_pop,
    input  wire             i_pop,
    output logic            o_empty,
    output logic     [7:0]  o_out_byte,
    output logic            o_frame_end
);
    import trfb_pkg::*;

    t_step      r_step;
    t_step      n_step;
    logic       r_started;
    logic       n_started;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;

    t_step      step;
    logic       load;
    logic       emit;
    logic       done;
    logic [7:0] byte_val;

    // Pick the current byte position and its value
    always_comb begin
        if (r_started) begin
            step = r_step;
        end else if (i_cmd.first) begin
            step = ST_SOF;
        end else begin
            step = ST_DATA;
        end
        case (step)
            ST_SOF:     byte_val = START_DELIM;
            ST_LEN_HI:  byte_val = LEN_HI;
            ST_LEN_LO:  byte_val = LEN_BASE + i_cmd.len;
            ST_TYPE:    byte_val = FRAME_TYPE;
            ST_FID:     byte_val = FRAME_ID;
            ST_ADDR0:   byte_val = i_cmd.addr[63:56];
            ST_ADDR1:   byte_val = i_cmd.addr[55:48];
            ST_ADDR2:   byte_val = i_cmd.addr[47:40];
            ST_ADDR3:   byte_val = i_cmd.addr[39:32];
            ST_ADDR4:   byte_val = i_cmd.addr[31:24];
            ST_ADDR5:   byte_val = i_cmd.addr[23:16];
            ST_ADDR6:   byte_val = i_cmd.addr[15:8];
            ST_ADDR7:   byte_val = i_cmd.addr[7:0];
            ST_NET_HI:  byte_val = NET_ADDR_HI;
            ST_NET_LO:  byte_val = NET_ADDR_LO;
            ST_RADIUS:  byte_val = ZERO_BYTE;
            ST_OPTIONS: byte_val = ZERO_BYTE;
            ST_DATA:    byte_val = i_cmd.data;
            ST_CSUM:    byte_val = ~r_sum;
            default:    byte_val = ZERO_BYTE;
        endcase
    end

    // Sequence the next position, the checksum and the queue pop
    always_comb begin
        load      = !r_out_valid || i_pop;
        emit      = !i_q_empty && load;
        n_step    = r_step;
        n_started = r_started;
        n_sum     = r_sum;
        done      = 1'b0;
        case (step)
            ST_OPTIONS: n_step = i_cmd.has_data ? ST_DATA : ST_CSUM;
            ST_DATA: begin
                n_step = ST_CSUM;
                done   = !i_cmd.last;
            end
            ST_CSUM:    done   = 1'b1;
            default:    n_step = t_step'(step + 5'd1);
        endcase
        if (emit) begin
            n_started = !done;
            if (step == ST_TYPE) begin
                n_sum = FRAME_TYPE;
            end else if (step inside {[ST_FID:ST_DATA]}) begin
                n_sum = r_sum + byte_val;
            end
        end
        o_q_pop = emit && done;
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_SOF;
            r_started <= 1'b0;
            r_sum     <= 8'd0;
        end else if (emit) begin
            r_step    <= n_step;
            r_started <= n_started;
            r_sum     <= n_sum;
        end
    end

    // Output register: load when free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= byte_val;
            r_out_end  <= (step == ST_CSUM);
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_out_end;

    `TRFB_ASSERT_IMPLY(a_started_has_cmd, i_clk, i_rst_n, r_started, !i_q_empty)
    `TRFB_ASSERT_NEXT(a_csum_flags_end, i_clk, i_rst_n, emit && (step == ST_CSUM), r_out_end && r_out_valid)
    `TRFB_ASSERT_IMPLY(a_pop_only_done, i_clk, i_rst_n, o_q_pop, emit && (step == ST_DATA || step == ST_CSUM))

endmodule
`default_nettype wire

// ----- rtl/core/transmit_request_frame_builder.sv -----
// Top level of the transmit-request frame builder.
//
// Input channel (push/full): one beat per payload byte. The beat that opens
// a frame also supplies the destination address and payload length; later
// beats of the frame carry only the payload byte. A zero length opens and
// closes a frame in one beat with no payload.
// Result channel (empty/pop): one frame byte per beat, in transmit order;
// o_frame_end marks the checksum byte.
// The first byte of a beat passes the command queue and then the output
// register on its way to the result ports.
// A frame-opening beat yields 18 or 19 bytes; any other beat yields one
// byte, or two on the frame's last beat. The back-end sequencer emits one
// byte per cycle while the receiver keeps popping.
// A four-entry command queue decouples the front from the sequencer, so up
// to three further input beats are taken while a header is streamed out.
// Reset (synchronous, active low) empties the queue and output register
// and closes any open frame.
// When the receiver stops popping, the output byte holds, the sequencer
// stalls, and full rises once the command queue fills.
`default_nettype none
module transmit_request_frame_builder (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        push,
    output logic       full,
    input  wire [63:0] i_dest_address,
    input  wire [7:0]  i_payload_length,
    input  wire [7:0]  i_payload_byte,
    output logic       empty,
    input  wire        pop,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end
);
    import trfb_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    assign full = q_full;

    // Classify beats
    trfb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_q_full         (q_full),
        .i_dest_address   (i_dest_address),
        .i_payload_length (i_payload_length),
        .i_payload_byte   (i_payload_byte),
        .o_q_push         (q_push),
        .o_cmd            (front_cmd)
    );

    // Queue classified commands
    trfb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // Stream frame bytes
    trfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (head_cmd),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

endmodule
`default_nettype wire
